// File: sv/midpoint_circle_rasterizer_unit_macros.svh
// ----------------------------------------------------------------------------
// midpoint circle rasterizer assertion macros
// shared helpers for clocked checks with synchronous active-low reset
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_CIRCLE_RASTERIZER_UNIT_MACROS_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_UNIT_MACROS_SVH

// same-cycle implication
`define MCR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// next-cycle implication
`define MCR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// File: sv/mcr_pkg.sv
// ----------------------------------------------------------------------------
// mcr_pkg
// widths, codes and the set descriptor shared by the circle rasterizer
// ----------------------------------------------------------------------------
package mcr_pkg;

  // field widths
  localparam int CoordW   = 11;
  localparam int RadiusW  = 10;
  localparam int OffXW    = 11;
  localparam int OffYW    = 12;
  localparam int DecW     = 16;
  localparam int PixW     = 12;
  localparam int InDataW  = 32;
  localparam int OutDataW = 24;

  // midpoint rule constants
  localparam int DecStart  = 3;
  localparam int DecStepE  = 6;
  localparam int DecStepSe = 10;

  // pixels per symmetric set
  localparam int SetPix  = 8;
  localparam int PixIdxW = $clog2(SetPix);

  // default depth of the set queue
  localparam int QueueDepthDef = 2;

  // input item kind
  typedef enum logic {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } kind_t;

  // one symmetric set to be drawn
  typedef struct packed {
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic [OffXW-1:0]  ox;
    logic [OffYW-1:0]  oy;
    logic              done;
  } set_t;

endpackage

// File: sv/mcr_queue.sv
// ----------------------------------------------------------------------------
// mcr_queue
// short register queue of set descriptors between front and back
// ----------------------------------------------------------------------------
`include "midpoint_circle_rasterizer_unit_macros.svh"

module mcr_queue import mcr_pkg::*; #(
  parameter int Depth = QueueDepthDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  set_t push_set,
  output logic full,
  input  logic pop,
  output set_t head,
  output logic empty
);

  localparam int IdxW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  set_t            mem_r [Depth];
  logic [IdxW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [IdxW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            wr, rd;
  logic            count_ok;

  assign full  = (count_r == CntW'(Depth));
  assign empty = (count_r == '0);
  assign wr    = push & ~full;
  assign rd    = pop & ~empty;
  assign head  = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr) begin
      wr_ptr_nxt = (wr_ptr_r == IdxW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd) begin
      rd_ptr_nxt = (rd_ptr_r == IdxW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr && !rd) begin
      count_nxt = count_r + 1'b1;
    end else if (rd && !wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wr_ptr_r] <= push_set;
    end
  end

  assign count_ok = (count_r <= CntW'(Depth));

  `MCR_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_ok)
  `MCR_ASSERT_NXT(a_count_up, clk, rst_n, wr && !rd, count_r == $past(count_r) + 1'b1)
  `MCR_ASSERT_NXT(a_count_down, clk, rst_n, rd && !wr, count_r == $past(count_r) - 1'b1)

endmodule

// File: sv/mcr_front.sv
// ----------------------------------------------------------------------------
// mcr_front
// accepts items, runs the midpoint rule and queues one set per start or active step
// ----------------------------------------------------------------------------
`include "midpoint_circle_rasterizer_unit_macros.svh"

module mcr_front import mcr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  kind_t              in_kind,
  input  logic [CoordW-1:0]  in_cx,
  input  logic [CoordW-1:0]  in_cy,
  input  logic [RadiusW-1:0] in_radius,
  input  logic               q_full,
  output logic               push,
  output set_t               push_set
);

  logic [CoordW-1:0] cx_r, cx_nxt;
  logic [CoordW-1:0] cy_r, cy_nxt;
  logic [OffXW-1:0]  ox_r, ox_nxt;
  logic [OffYW-1:0]  oy_r, oy_nxt;
  logic [DecW-1:0]   dec_r, dec_nxt;
  logic              active_r, active_nxt;
  logic              accept;
  logic              gen;
  logic              done;
  logic [OffXW-1:0]  ox_inc;
  logic [OffYW-1:0]  oy_dec;
  logic [DecW-1:0]   diff;
  logic              order_nxt;
  logic              order_ok;

  assign in_ready = ~q_full;
  assign accept   = in_valid & ~q_full;
  assign ox_inc   = ox_r + 1'b1;
  assign oy_dec   = oy_r - 1'b1;
  assign diff     = {{(DecW-OffXW){1'b0}}, ox_inc} - {{(DecW-OffYW){oy_dec[OffYW-1]}}, oy_dec};

  // offset_y >= offset_x on the candidate offsets, signed compare
  assign order_nxt = $signed({oy_nxt[OffYW-1], oy_nxt}) >= $signed({2'b00, ox_nxt});
  assign order_ok  = $signed({oy_r[OffYW-1], oy_r}) >= $signed({2'b00, ox_r});

  // start or midpoint step
  always_comb begin
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    dec_nxt    = dec_r;
    active_nxt = active_r;
    gen        = 1'b0;
    done       = 1'b0;
    if (in_kind == KIND_START) begin
      cx_nxt     = in_cx;
      cy_nxt     = in_cy;
      ox_nxt     = '0;
      oy_nxt     = {{(OffYW-RadiusW){1'b0}}, in_radius};
      dec_nxt    = DecW'(DecStart) - {{(DecW-RadiusW-1){1'b0}}, in_radius, 1'b0};
      active_nxt = 1'b1;
      gen        = 1'b1;
    end else if (active_r) begin
      ox_nxt = ox_inc;
      if (dec_r[DecW-1]) begin
        dec_nxt = dec_r + {{(DecW-OffXW-2){1'b0}}, ox_inc, 2'b00} + DecW'(DecStepE);
      end else begin
        oy_nxt  = oy_dec;
        dec_nxt = dec_r + {diff[DecW-3:0], 2'b00} + DecW'(DecStepSe);
      end
      active_nxt = order_nxt;
      done       = ~order_nxt;
      gen        = 1'b1;
    end
  end

  assign push          = accept & gen;
  assign push_set.cx   = cx_nxt;
  assign push_set.cy   = cy_nxt;
  assign push_set.ox   = ox_nxt;
  assign push_set.oy   = oy_nxt;
  assign push_set.done = done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r     <= '0;
      cy_r     <= '0;
      ox_r     <= '0;
      oy_r     <= '0;
      dec_r    <= '0;
      active_r <= 1'b0;
    end else if (accept) begin
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      ox_r     <= ox_nxt;
      oy_r     <= oy_nxt;
      dec_r    <= dec_nxt;
      active_r <= active_nxt;
    end
  end

  `MCR_ASSERT_IMP(a_active_order, clk, rst_n, active_r, order_ok)
  `MCR_ASSERT_NXT(a_start_arms, clk, rst_n, accept && in_kind == KIND_START, active_r && ox_r == '0)
  `MCR_ASSERT_IMP(a_idle_step_drops, clk, rst_n, accept && in_kind == KIND_STEP && !active_r, !push)

endmodule

// File: sv/mcr_back.sv
// ----------------------------------------------------------------------------
// mcr_back
// walks one queued set through its eight mirrored pixels into the output register
// ----------------------------------------------------------------------------
`include "midpoint_circle_rasterizer_unit_macros.svh"

module mcr_back import mcr_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  set_t            head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [PixW-1:0] out_px,
  output logic [PixW-1:0] out_py,
  output logic            out_last,
  output logic            out_done
);

  localparam logic [PixIdxW-1:0] LastIdx = PixIdxW'(SetPix - 1);

  set_t               cur_r;
  logic               busy_r, busy_nxt;
  logic [PixIdxW-1:0] idx_r, idx_nxt;
  logic               valid_r, valid_nxt;
  logic [PixW-1:0]    px_r, py_r;
  logic               last_r, done_r;
  logic               adv;
  logic [PixW-1:0]    cx12, cy12, ox12, a_sel, b_sel, px_nxt, py_nxt;

  // a pixel is produced when the output register is free or draining
  assign adv = busy_r & (~valid_r | out_ready);
  assign pop = ~q_empty & (~busy_r | (adv & (idx_r == LastIdx)));

  // mirrored pixel for the current index
  assign cx12   = {cur_r.cx[CoordW-1], cur_r.cx};
  assign cy12   = {cur_r.cy[CoordW-1], cur_r.cy};
  assign ox12   = {1'b0, cur_r.ox};
  assign a_sel  = idx_r[2] ? cur_r.oy : ox12;
  assign b_sel  = idx_r[2] ? ox12 : cur_r.oy;
  assign px_nxt = idx_r[0] ? cx12 - a_sel : cx12 + a_sel;
  assign py_nxt = idx_r[1] ? cy12 - b_sel : cy12 + b_sel;

  // sequencing
  always_comb begin
    busy_nxt  = busy_r;
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (adv) begin
      idx_nxt = idx_r + 1'b1;
      if (idx_r == LastIdx) begin
        busy_nxt = 1'b0;
      end
    end
    if (adv) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head;
    end
    if (adv) begin
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      last_r <= (idx_r == LastIdx);
      done_r <= cur_r.done;
    end
  end

  assign out_valid = valid_r;
  assign out_px    = px_r;
  assign out_py    = py_r;
  assign out_last  = last_r;
  assign out_done  = done_r;

  `MCR_ASSERT_NXT(a_pop_loads, clk, rst_n, pop, busy_r && idx_r == '0)
  `MCR_ASSERT_NXT(a_adv_shows, clk, rst_n, adv, valid_r)
  `MCR_ASSERT_NXT(a_idx_holds, clk, rst_n, busy_r && !adv && !pop, idx_r == $past(idx_r))

endmodule

// File: sv/midpoint_circle_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_unit
// midpoint circle rasterizer: start and step items in, mirrored pixels out
// ----------------------------------------------------------------------------
// in_*  : one item per handshake; in_tuser is the kind (0 start, 1 step),
//         in_tdata carries center and radius, used by start items only
// out_* : one pixel per handshake; out_tlast marks the eighth pixel of a set,
//         out_tuser marks every pixel of the circle's final set
// a start or an active step item yields eight pixels; a step with no circle
// in progress yields none
// the first pixel of an item passes the set queue, the sequencer's current-set register and the output register
// throughput: one pixel per cycle while sets are queued and out_tready is high,
// set by the single pixel sequencer feeding the output register
// the front takes a new item whenever the set queue has room, so it keeps
// running ahead of the pixel sequencer by up to QueueDepth sets
// reset clears the circle state, the queue and the output valid at once
// when the receiver stalls, the output holds, the sequencer waits and the
// queue fills; in_tready then drops until a set is taken
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_unit import mcr_pkg::*; #(
  parameter int QueueDepth = QueueDepthDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,   // center_x[10:0], center_y[21:11], radius[31:22]
  input  logic                in_tuser,   // kind
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,  // pixel_x[11:0], pixel_y[23:12]
  output logic                out_tlast,
  output logic                out_tuser   // circle_done
);

  logic signed [CoordW-1:0] in_center_x;
  logic signed [CoordW-1:0] in_center_y;
  logic [RadiusW-1:0]       in_radius;
  logic signed [PixW-1:0]   out_pixel_x;
  logic signed [PixW-1:0]   out_pixel_y;
  logic                     q_push, q_full, q_pop, q_empty;
  set_t                     q_in, q_head;

  // unpack input fields
  assign in_center_x = in_tdata[CoordW-1:0];
  assign in_center_y = in_tdata[2*CoordW-1:CoordW];
  assign in_radius   = in_tdata[2*CoordW+RadiusW-1:2*CoordW];

  mcr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_kind   (kind_t'(in_tuser)),
    .in_cx     (in_center_x),
    .in_cy     (in_center_y),
    .in_radius (in_radius),
    .q_full    (q_full),
    .push      (q_push),
    .push_set  (q_in)
  );

  mcr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_set (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  mcr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .head      (q_head),
    .pop       (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_px    (out_pixel_x),
    .out_py    (out_pixel_y),
    .out_last  (out_tlast),
    .out_done  (out_tuser)
  );

  // pack output fields
  assign out_tdata = {out_pixel_y, out_pixel_x};

endmodule
